/* design/status_led_blink_code_sequencer_defines.svh */
// ---------------------------------------------------------------------------
// status led blink code sequencer: assertion macros
// ---------------------------------------------------------------------------
`ifndef STATUS_LED_BLINK_CODE_SEQUENCER_DEFINES_SVH
`define STATUS_LED_BLINK_CODE_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SLBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/slbc_pkg.sv */
// ---------------------------------------------------------------------------
// slbc_pkg
// shared types and constants of the status led blink code sequencer
// ---------------------------------------------------------------------------
package slbc_pkg;

   typedef enum logic [1:0] {
      MODE_UNCAL  = 2'd0,
      MODE_UNSET  = 2'd1,
      MODE_NORMAL = 2'd2
   } mode_type;

   localparam logic [7:0] MARK_OK    = 8'hA5;
   localparam logic [7:0] COIL_GONE  = 8'h01;

   // error code bit positions
   localparam int ERR_RANGE   = 0;
   localparam int ERR_EEPROM  = 1;
   localparam int ERR_UNREACH = 2;
   localparam int ERR_COIL    = 3;

   // decoded request as held in the input register
   typedef struct packed {
      mode_type   mode;
      logic [3:0] check_ok;
      logic [3:0] err;
   } decode_type;

endpackage

/* design/slbc_channels.sv */
// ---------------------------------------------------------------------------
// slbc channels
// request and response channel interfaces, valid/ready handshake
// ---------------------------------------------------------------------------
interface slbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sensor_mark;
   logic [7:0] ctrl_mark_a;
   logic [7:0] ctrl_mark_b;
   logic [7:0] feedback_mark;
   logic [7:0] intake_coil_state;
   logic [7:0] exhaust_coil_state;
   logic [7:0] range_mark;
   logic [7:0] ctrl_type_mark;
   logic [7:0] feedback_type_mark;
   logic [7:0] product_mark;
   logic [7:0] error_code;

   modport source (
      output valid, sensor_mark, ctrl_mark_a, ctrl_mark_b, feedback_mark,
             intake_coil_state, exhaust_coil_state, range_mark, ctrl_type_mark,
             feedback_type_mark, product_mark, error_code,
      input  ready
   );
   modport sink (
      input  valid, sensor_mark, ctrl_mark_a, ctrl_mark_b, feedback_mark,
             intake_coil_state, exhaust_coil_state, range_mark, ctrl_type_mark,
             feedback_type_mark, product_mark, error_code,
      output ready
   );
endinterface

interface slbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       red_on;
   logic       green_on;
   logic [1:0] mode;

   modport source (output valid, red_on, green_on, mode, input ready);
   modport sink (input valid, red_on, green_on, mode, output ready);
endinterface

/* design/slbc_front.sv */
// ---------------------------------------------------------------------------
// slbc_front
// input register: takes a request, decodes marker bytes into mode and checks
// ---------------------------------------------------------------------------
module slbc_front (
   input  logic                clock,
   input  logic                reset,
   slbc_req_if.sink            req_chan,
   input  logic                advance,
   output logic                valid,
   output slbc_pkg::decode_type dec
);

   logic                 valid_ff;
   logic                 valid_in;
   slbc_pkg::decode_type dec_ff;
   slbc_pkg::decode_type dec_in;
   logic                 take;
   logic [3:0]           cal;
   logic [3:0]           set;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      cal[0] = (req_chan.sensor_mark == slbc_pkg::MARK_OK);
      cal[1] = (req_chan.ctrl_mark_a == slbc_pkg::MARK_OK) ||
               (req_chan.ctrl_mark_b == slbc_pkg::MARK_OK);
      cal[2] = (req_chan.feedback_mark == slbc_pkg::MARK_OK);
      cal[3] = !((req_chan.intake_coil_state == slbc_pkg::COIL_GONE) ||
                 (req_chan.exhaust_coil_state == slbc_pkg::COIL_GONE));
      set[0] = (req_chan.range_mark == slbc_pkg::MARK_OK);
      set[1] = (req_chan.ctrl_type_mark == slbc_pkg::MARK_OK);
      set[2] = (req_chan.feedback_type_mark == slbc_pkg::MARK_OK);
      set[3] = (req_chan.product_mark == slbc_pkg::MARK_OK);

      dec_in.err = req_chan.error_code[3:0];
      if (!(&cal)) begin
         dec_in.mode     = slbc_pkg::MODE_UNCAL;
         dec_in.check_ok = cal;
      end else if (!(&set)) begin
         dec_in.mode     = slbc_pkg::MODE_UNSET;
         dec_in.check_ok = set;
      end else begin
         dec_in.mode     = slbc_pkg::MODE_NORMAL;
         dec_in.check_ok = set;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dec_ff <= dec_in;
      end
   end

   assign valid = valid_ff;
   assign dec   = dec_ff;

endmodule

/* design/slbc_led_core.sv */
// ---------------------------------------------------------------------------
// slbc_led_core
// phase counters and led levels, one update per processed request
// ---------------------------------------------------------------------------
module slbc_led_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  slbc_pkg::decode_type dec,
   output logic                 red_next,
   output logic                 green_next
);

   localparam logic [6:0] UNCAL_LAST  = 7'd125;
   localparam logic [7:0] UNSET_LAST  = 8'd134;
   localparam logic [5:0] SLOW_LAST   = 6'd39;
   localparam logic [4:0] FAST_LAST   = 5'd19;
   localparam logic [6:0] UNCAL_PRE   = 7'd40;
   localparam logic [7:0] UNSET_PRE   = 8'd52;
   localparam logic [5:0] SLOW_HALF   = 6'd20;
   localparam logic [4:0] FAST_HALF   = 5'd10;
   localparam logic [6:0] SLOT_STEP   = 7'd20;
   localparam logic [6:0] SLOT_ON_LEN = 7'd16;

   logic       red_ff, red_in;
   logic       green_ff, green_in;
   logic [6:0] phase_126_ff, phase_126_in;
   logic [7:0] phase_135_ff, phase_135_in;
   logic [5:0] phase_40_ff, phase_40_in;
   logic [4:0] phase_20_ff, phase_20_in;
   logic [6:0] unset_rel;
   logic [6:0] uncal_rel;

   // four report slots: flash on at slot start, both off 16 ticks later
   function automatic logic [1:0] report_slots(input logic [6:0] rel,
                                               input logic [3:0] ok,
                                               input logic red_cur,
                                               input logic green_cur);
      logic       r;
      logic       g;
      logic [6:0] on_step;
      r = red_cur;
      g = green_cur;
      for (int k = 0; k < 4; k++) begin
         on_step = SLOT_STEP * 7'(k);
         if (rel == on_step) begin
            if (ok[k]) begin
               g = 1'b1;
            end else begin
               r = 1'b1;
            end
         end else if (rel == on_step + SLOT_ON_LEN) begin
            g = 1'b0;
            r = 1'b0;
         end
      end
      return {r, g};
   endfunction

   assign uncal_rel = phase_126_ff - UNCAL_PRE;
   // report part of the unset cycle spans 83 ticks, seven bits are enough
   assign unset_rel = 7'(phase_135_ff - UNSET_PRE);

   always_comb begin
      red_in   = red_ff;
      green_in = green_ff;
      case (dec.mode)
         slbc_pkg::MODE_UNCAL: begin
            if (phase_126_ff < UNCAL_PRE) begin
               green_in = (phase_126_ff < 7'd3) ||
                          (phase_126_ff >= 7'd6 && phase_126_ff < 7'd9) ||
                          (phase_126_ff >= 7'd18 && phase_126_ff < 7'd21) ||
                          (phase_126_ff >= 7'd24 && phase_126_ff < 7'd27);
            end else begin
               {red_in, green_in} = report_slots(uncal_rel, dec.check_ok,
                                                 red_ff, green_ff);
            end
         end
         slbc_pkg::MODE_UNSET: begin
            if (phase_135_ff < UNSET_PRE) begin
               green_in = (phase_135_ff < 8'd3) ||
                          (phase_135_ff >= 8'd6 && phase_135_ff < 8'd9) ||
                          (phase_135_ff >= 8'd12 && phase_135_ff < 8'd15) ||
                          (phase_135_ff >= 8'd24 && phase_135_ff < 8'd27) ||
                          (phase_135_ff >= 8'd30 && phase_135_ff < 8'd33) ||
                          (phase_135_ff >= 8'd36 && phase_135_ff < 8'd39);
            end else begin
               {red_in, green_in} = report_slots(unset_rel, dec.check_ok,
                                                 red_ff, green_ff);
            end
         end
         slbc_pkg::MODE_NORMAL: begin
            // error priority: range, unreachable, eeprom, coil
            if (dec.err[slbc_pkg::ERR_RANGE]) begin
               red_in = (phase_40_ff < SLOW_HALF);
            end else if (dec.err[slbc_pkg::ERR_UNREACH]) begin
               red_in   = (phase_20_ff < FAST_HALF);
               green_in = 1'b0;
            end else if (dec.err[slbc_pkg::ERR_EEPROM]) begin
               red_in   = 1'b1;
               green_in = 1'b0;
            end else if (dec.err[slbc_pkg::ERR_COIL]) begin
               red_in   = (phase_20_ff < FAST_HALF);
               green_in = !(phase_20_ff < FAST_HALF);
            end
         end
         default: begin
            red_in   = red_ff;
            green_in = green_ff;
         end
      endcase
   end

   always_comb begin
      phase_126_in = (phase_126_ff == UNCAL_LAST) ? '0 : phase_126_ff + 7'd1;
      phase_135_in = (phase_135_ff == UNSET_LAST) ? '0 : phase_135_ff + 8'd1;
      phase_40_in  = (phase_40_ff == SLOW_LAST)   ? '0 : phase_40_ff + 6'd1;
      phase_20_in  = (phase_20_ff == FAST_LAST)   ? '0 : phase_20_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff       <= 1'b0;
         green_ff     <= 1'b0;
         phase_126_ff <= '0;
         phase_135_ff <= '0;
         phase_40_ff  <= '0;
         phase_20_ff  <= '0;
      end else if (step) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         phase_126_ff <= phase_126_in;
         phase_135_ff <= phase_135_in;
         phase_40_ff  <= phase_40_in;
         phase_20_ff  <= phase_20_in;
      end
   end

   assign red_next   = red_in;
   assign green_next = green_in;

endmodule

/* design/status_led_blink_code_sequencer.sv */
// ---------------------------------------------------------------------------
// status_led_blink_code_sequencer
// status led blink code sequencer, one request per 50 ms tick
// ---------------------------------------------------------------------------
// usage:
//   req_chan carries one tick: ten marker/coil bytes and the error code.
//   rsp_chan returns one response per request: red_on, green_on and mode.
//   a request goes into the input register at the accepting edge; when
//   the response register is free or being taken, the led and phase
//   state update and the response register loads, raising rsp_chan.valid.
//   throughput is one request per cycle while rsp_chan.ready stays high:
//   the input and response registers each pass on as the next stage frees
//   up, and the state update is a single compare pass on the phase counters.
//   reset clears both leds, the four phase counters and both valid flags;
//   the first response after reset reflects phase zero.
//   when rsp_chan.ready stays low, the response holds, one more request
//   waits in the input register, and req_chan.ready then drops until the
//   response is taken. no request is dropped or repeated.
// ---------------------------------------------------------------------------
`include "status_led_blink_code_sequencer_defines.svh"

module status_led_blink_code_sequencer (
   input  logic       clock,
   input  logic       reset,
   slbc_req_if.sink   req_chan,
   slbc_rsp_if.source rsp_chan
);

   logic                 front_valid;
   slbc_pkg::decode_type front_dec;
   logic                 step;
   logic                 red_next;
   logic                 green_next;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_red_ff;
   logic                 rsp_green_ff;
   logic [1:0]           rsp_mode_ff;
   logic                 req_take;
   logic                 eeprom_step;
   logic                 eeprom_shown;

   assign step = front_valid && (!rsp_valid_ff || rsp_chan.ready);

   slbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (step),
      .valid    (front_valid),
      .dec      (front_dec)
   );

   slbc_led_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .dec        (front_dec),
      .red_next   (red_next),
      .green_next (green_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_red_ff   <= red_next;
         rsp_green_ff <= green_next;
         rsp_mode_ff  <= front_dec.mode;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.red_on   = rsp_red_ff;
   assign rsp_chan.green_on = rsp_green_ff;
   assign rsp_chan.mode     = rsp_mode_ff;

   assign req_take     = req_chan.valid && req_chan.ready;
   // eeprom error with neither a range nor an unreachable error set
   assign eeprom_step  = step && front_dec.mode == slbc_pkg::MODE_NORMAL &&
                         !front_dec.err[slbc_pkg::ERR_RANGE] &&
                         !front_dec.err[slbc_pkg::ERR_UNREACH] &&
                         front_dec.err[slbc_pkg::ERR_EEPROM];
   assign eeprom_shown = rsp_chan.red_on && !rsp_chan.green_on;

   // a new request never overwrites one that has not moved on
   `SLBC_ASSERT_NOW(a_no_overrun, clock, reset, req_take && front_valid, step, "input overrun")

   // a processed request always shows up as a response
   `SLBC_ASSERT_NEXT(a_step_to_rsp, clock, reset, step, rsp_chan.valid, "request lost")

   // eeprom error forces red on, green off
   `SLBC_ASSERT_NEXT(a_eeprom_pattern, clock, reset, eeprom_step, eeprom_shown, "bad eeprom pattern")

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the status led blink code sequencer: marker and
// error-code ticks run in mode segments, mostly long enough to reach the report
// flashes. A scoreboard tracks the led levels and phase counters and checks
// every response, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_TICKS = 450;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [7:0] sensor_mark;
      logic [7:0] ctrl_mark_a;
      logic [7:0] ctrl_mark_b;
      logic [7:0] feedback_mark;
      logic [7:0] intake_coil_state;
      logic [7:0] exhaust_coil_state;
      logic [7:0] range_mark;
      logic [7:0] ctrl_type_mark;
      logic [7:0] feedback_type_mark;
      logic [7:0] product_mark;
      logic [7:0] error_code;
   } tick_type;

   typedef struct packed {
      logic               red;
      logic               green;
      slbc_pkg::mode_type mode;
   } led_state_type;

   class led_scoreboard;
      bit            red_lvl;
      bit            green_lvl;
      bit [6:0]      ph126;
      bit [7:0]      ph135;
      bit [5:0]      ph40;
      bit [4:0]      ph20;
      led_state_type expected_leds[$];
      int            failures;

      function void flash_slots(int p, int base, bit [3:0] ok);
         for (int k = 0; k < 4; k++) begin
            if (p == base + 20 * k) begin
               if (ok[k]) green_lvl = 1'b1;
               else red_lvl = 1'b1;
            end else if (p == base + 20 * k + 16) begin
               green_lvl = 1'b0;
               red_lvl = 1'b0;
            end
         end
      endfunction

      // update led levels and phases for one accepted tick
      function void note_tick(tick_type t);
         bit [3:0]           cal;
         bit [3:0]           setok;
         slbc_pkg::mode_type m;
         led_state_type      e;
         cal[0] = (t.sensor_mark == slbc_pkg::MARK_OK);
         cal[1] = (t.ctrl_mark_a == slbc_pkg::MARK_OK) ||
                  (t.ctrl_mark_b == slbc_pkg::MARK_OK);
         cal[2] = (t.feedback_mark == slbc_pkg::MARK_OK);
         cal[3] = !((t.intake_coil_state == slbc_pkg::COIL_GONE) ||
                    (t.exhaust_coil_state == slbc_pkg::COIL_GONE));
         setok[0] = (t.range_mark == slbc_pkg::MARK_OK);
         setok[1] = (t.ctrl_type_mark == slbc_pkg::MARK_OK);
         setok[2] = (t.feedback_type_mark == slbc_pkg::MARK_OK);
         setok[3] = (t.product_mark == slbc_pkg::MARK_OK);
         if (cal != 4'hF) m = slbc_pkg::MODE_UNCAL;
         else if (setok != 4'hF) m = slbc_pkg::MODE_UNSET;
         else m = slbc_pkg::MODE_NORMAL;

         case (m)
            slbc_pkg::MODE_UNCAL: begin
               if (ph126 < 40)
                  green_lvl = (ph126 < 3) || (ph126 >= 6 && ph126 < 9) ||
                              (ph126 >= 18 && ph126 < 21) ||
                              (ph126 >= 24 && ph126 < 27);
               else
                  flash_slots(int'(ph126), 40, cal);
            end
            slbc_pkg::MODE_UNSET: begin
               if (ph135 < 52)
                  green_lvl = (ph135 < 3) || (ph135 >= 6 && ph135 < 9) ||
                              (ph135 >= 12 && ph135 < 15) ||
                              (ph135 >= 24 && ph135 < 27) ||
                              (ph135 >= 30 && ph135 < 33) ||
                              (ph135 >= 36 && ph135 < 39);
               else
                  flash_slots(int'(ph135), 52, setok);
            end
            default: begin
               // error priority: range, unreachable, eeprom, coil
               if (t.error_code[slbc_pkg::ERR_RANGE]) begin
                  red_lvl = (ph40 < 20);
               end else if (t.error_code[slbc_pkg::ERR_UNREACH]) begin
                  red_lvl = (ph20 < 10);
                  green_lvl = 1'b0;
               end else if (t.error_code[slbc_pkg::ERR_EEPROM]) begin
                  red_lvl = 1'b1;
                  green_lvl = 1'b0;
               end else if (t.error_code[slbc_pkg::ERR_COIL]) begin
                  red_lvl = (ph20 < 10);
                  green_lvl = !(ph20 < 10);
               end
            end
         endcase

         ph126 = (ph126 == 125) ? 7'd0 : ph126 + 7'd1;
         ph135 = (ph135 == 134) ? 8'd0 : ph135 + 8'd1;
         ph40 = (ph40 == 39) ? 6'd0 : ph40 + 6'd1;
         ph20 = (ph20 == 19) ? 5'd0 : ph20 + 5'd1;

         e.red = red_lvl;
         e.green = green_lvl;
         e.mode = m;
         expected_leds.push_back(e);
      endfunction

      function void check_leds(logic red, logic green, logic [1:0] mode);
         led_state_type e;
         if (expected_leds.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected response red=%b green=%b mode=%0d",
                        $realtime, red, green, mode);
            return;
         end
         e = expected_leds.pop_front();
         if (red !== e.red || green !== e.green || mode !== e.mode) begin
            failures++;
            if (failures <= 10)
               $display("%0t: mismatch red %b/%b green %b/%b mode %0d/%0d (exp/act)",
                        $realtime, e.red, red, e.green, green, e.mode, mode);
         end
      endfunction

      function int pending();
         return expected_leds.size();
      endfunction

      function void flush_leftovers();
         while (expected_leds.size() != 0) begin
            void'(expected_leds.pop_front());
            failures++;
            if (failures <= 10) $display("response never arrived");
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   responses_seen;
   int   idle_cycles;
   bit   stall_window;

   slbc_req_if req_chan ();
   slbc_rsp_if rsp_chan ();

   led_scoreboard board = new();

   status_led_blink_code_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] other_than(logic [7:0] v);
      logic [7:0] r;
      r = 8'($urandom);
      if (r == v) r = r ^ (8'd1 << $urandom_range(0, 7));
      return r;
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      t = 88'({$urandom, $urandom, $urandom});
      return t;
   endfunction

   function automatic tick_type passing_tick();
      tick_type t;
      t = random_tick();
      t.sensor_mark = slbc_pkg::MARK_OK;
      t.ctrl_mark_a = slbc_pkg::MARK_OK;
      t.ctrl_mark_b = slbc_pkg::MARK_OK;
      t.feedback_mark = slbc_pkg::MARK_OK;
      t.intake_coil_state = other_than(slbc_pkg::COIL_GONE);
      t.exhaust_coil_state = other_than(slbc_pkg::COIL_GONE);
      t.range_mark = slbc_pkg::MARK_OK;
      t.ctrl_type_mark = slbc_pkg::MARK_OK;
      t.feedback_type_mark = slbc_pkg::MARK_OK;
      t.product_mark = slbc_pkg::MARK_OK;
      t.error_code = 8'h00;
      return t;
   endfunction

   function automatic logic [7:0] mark_or_not(bit fail);
      return fail ? other_than(slbc_pkg::MARK_OK) : slbc_pkg::MARK_OK;
   endfunction

   function automatic logic [7:0] pick_error();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1, 2: return 8'd1 << $urandom_range(0, 3);
         3: return {4'($urandom), 4'h0};
         default: return 8'($urandom);
      endcase
   endfunction

   // a tick whose pass/fail pattern matches the segment, random content otherwise
   function automatic tick_type build_tick(slbc_pkg::mode_type m, bit [3:0] fail,
                                           logic [7:0] err);
      tick_type t;
      bit [3:0] cal_fail;
      bit [3:0] set_fail;
      t = random_tick();
      cal_fail = (m == slbc_pkg::MODE_UNCAL) ? fail : 4'h0;
      case (m)
         slbc_pkg::MODE_UNCAL: set_fail = 4'($urandom);
         slbc_pkg::MODE_UNSET: set_fail = fail;
         default:              set_fail = 4'h0;
      endcase
      t.sensor_mark = mark_or_not(cal_fail[0]);
      if (cal_fail[1]) begin
         t.ctrl_mark_a = other_than(slbc_pkg::MARK_OK);
         t.ctrl_mark_b = other_than(slbc_pkg::MARK_OK);
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               t.ctrl_mark_a = slbc_pkg::MARK_OK;
               t.ctrl_mark_b = slbc_pkg::MARK_OK;
            end
            1: begin
               t.ctrl_mark_a = slbc_pkg::MARK_OK;
               t.ctrl_mark_b = other_than(slbc_pkg::MARK_OK);
            end
            default: begin
               t.ctrl_mark_a = other_than(slbc_pkg::MARK_OK);
               t.ctrl_mark_b = slbc_pkg::MARK_OK;
            end
         endcase
      end
      t.feedback_mark = mark_or_not(cal_fail[2]);
      t.intake_coil_state = other_than(slbc_pkg::COIL_GONE);
      t.exhaust_coil_state = other_than(slbc_pkg::COIL_GONE);
      if (cal_fail[3]) begin
         case ($urandom_range(0, 2))
            0: t.intake_coil_state = slbc_pkg::COIL_GONE;
            1: t.exhaust_coil_state = slbc_pkg::COIL_GONE;
            default: begin
               t.intake_coil_state = slbc_pkg::COIL_GONE;
               t.exhaust_coil_state = slbc_pkg::COIL_GONE;
            end
         endcase
      end
      t.range_mark = mark_or_not(set_fail[0]);
      t.ctrl_type_mark = mark_or_not(set_fail[1]);
      t.feedback_type_mark = mark_or_not(set_fail[2]);
      t.product_mark = mark_or_not(set_fail[3]);
      if (m == slbc_pkg::MODE_NORMAL) t.error_code = err;
      return t;
   endfunction

   task automatic send_tick(input tick_type t);
      req_chan.valid <= 1'b1;
      req_chan.sensor_mark <= t.sensor_mark;
      req_chan.ctrl_mark_a <= t.ctrl_mark_a;
      req_chan.ctrl_mark_b <= t.ctrl_mark_b;
      req_chan.feedback_mark <= t.feedback_mark;
      req_chan.intake_coil_state <= t.intake_coil_state;
      req_chan.exhaust_coil_state <= t.exhaust_coil_state;
      req_chan.range_mark <= t.range_mark;
      req_chan.ctrl_type_mark <= t.ctrl_type_mark;
      req_chan.feedback_type_mark <= t.feedback_type_mark;
      req_chan.product_mark <= t.product_mark;
      req_chan.error_code <= t.error_code;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      board.note_tick(t);
   endtask

   task automatic drain_pause();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic idle_gap(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // response checking
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         board.check_leds(rsp_chan.red_on, rsp_chan.green_on, rsp_chan.mode);
         responses_seen++;
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int  style;
      int  len;
      int  step;
      bit  held;
      bit  r;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held && responses_seen >= 150) begin
            held = 1'b1;
            stall_window = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (64) @(posedge clock);
            stall_window = 1'b0;
         end
         style = $urandom_range(0, 3);
         len = $urandom_range(16, 80);
         for (step = 0; step < len; step++) begin
            case (style)
               0: r = 1'b1;
               1: r = 1'($urandom_range(0, 1));
               2: r = (step % 5) < 3;
               default: r = ($urandom_range(0, 3) == 0);
            endcase
            rsp_chan.ready <= r;
            @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin
      tick_type           t;
      slbc_pkg::mode_type seg_mode;
      bit [3:0]           seg_mask;
      logic [7:0]         seg_err;
      int                 seg_left;
      int                 burst_left;
      int                 gap;

      responses_seen = 0;
      idle_cycles = 0;
      stall_window = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.sensor_mark <= 8'h00;
      req_chan.ctrl_mark_a <= 8'h00;
      req_chan.ctrl_mark_b <= 8'h00;
      req_chan.feedback_mark <= 8'h00;
      req_chan.intake_coil_state <= 8'h00;
      req_chan.exhaust_coil_state <= 8'h00;
      req_chan.range_mark <= 8'h00;
      req_chan.ctrl_type_mark <= 8'h00;
      req_chan.feedback_type_mark <= 8'h00;
      req_chan.product_mark <= 8'h00;
      req_chan.error_code <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: error priorities, marker extremes, checks but ctrl failing alone
      for (int i = 0; i < 22; i++) begin
         t = passing_tick();
         case (i)
            1: t.error_code = 8'h01;
            2: t.error_code = 8'h04;
            3: t.error_code = 8'h02;
            4: t.error_code = 8'h08;
            5: t.error_code = 8'hF0;
            6: t.error_code = 8'hFF;
            7: t = '0;
            8: t = '1;
            9: t.intake_coil_state = slbc_pkg::COIL_GONE;
            10: t.exhaust_coil_state = slbc_pkg::COIL_GONE;
            11: t.ctrl_mark_b = 8'h00;
            12: t.ctrl_mark_a = 8'hFF;
            13: t.range_mark = 8'h00;
            14: t.ctrl_type_mark = 8'h5A;
            15: t.feedback_type_mark = 8'hA4;
            16: t.product_mark = 8'hA6;
            17: t.sensor_mark = 8'hA4;
            18: t.feedback_mark = 8'h25;
            19: t.error_code = 8'h05;
            20: t.error_code = 8'h0E;
            21: t.error_code = 8'h0A;
            default: ;
         endcase
         send_tick(t);
      end
      drain_pause();

      seg_left = 0;
      seg_mode = slbc_pkg::MODE_NORMAL;
      seg_mask = 4'h1;
      seg_err = 8'h00;
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < RANDOM_TICKS; n++) begin
         if (seg_left == 0) begin
            case ($urandom_range(0, 2))
               0: seg_mode = slbc_pkg::MODE_UNCAL;
               1: seg_mode = slbc_pkg::MODE_UNSET;
               default: seg_mode = slbc_pkg::MODE_NORMAL;
            endcase
            seg_mask = 4'($urandom_range(1, 15));
            seg_err = pick_error();
            // mostly long segments so the report flashes come around
            seg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 20)
                                                   : $urandom_range(60, 150);
         end
         seg_left--;
         if (seg_mode == slbc_pkg::MODE_NORMAL && $urandom_range(0, 24) == 0)
            seg_err = pick_error();
         if ($urandom_range(0, 19) == 0) t = random_tick();
         else t = build_tick(seg_mode, seg_mask, seg_err);
         send_tick(t);

         if (n == 250) begin
            drain_pause();
         end else begin
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25)
                                                 : $urandom_range(1, 4);
               // keep offering while the receiver is held off
               if (!stall_window) idle_gap(gap);
            end
         end
      end

      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.flush_leftovers();
      if (board.failures == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
